// File: rtl/core/text_line_formatter_unit_macros.svh
// Assertion macros used by the checker of the text line formatter.
`ifndef TEXT_LINE_FORMATTER_UNIT_MACROS_SVH
`define TEXT_LINE_FORMATTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text_line_formatter_unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text_line_formatter_unit: next-cycle check failed");

`endif

// File: rtl/core/tlf_pkg.sv
// Package with the types, codes and constants of the text line formatter.
`timescale 1ns / 1ps

package tlf_pkg;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] COL_MAX  = 8'd255;
    localparam logic [7:0] MIN_WIDTH = 8'd32;
    localparam int         MAX_TAB  = 16;
    localparam int         PREFIX_COLS = 6;

    typedef enum logic [2:0] {
        CFG_SKIP_EMPTY   = 3'd0,
        CFG_TO_LOWER     = 3'd1,
        CFG_TO_UPPER     = 3'd2,
        CFG_NUMBER_LINES = 3'd3,
        CFG_EXPAND_TABS  = 3'd4,
        CFG_WRAP_ENABLE  = 3'd5,
        CFG_TAB_WIDTH    = 3'd6,
        CFG_LINE_WIDTH   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PREFIX,
        S_BODY,
        S_DIV,
        S_TABCHK,
        S_SPACES
    } t_state;

    typedef enum logic [1:0] {
        SEL_PREFIX,
        SEL_NL,
        SEL_CHAR,
        SEL_SPACE
    } t_sel;

    typedef struct packed {
        logic load;
        logic push;
        t_sel sel;
        logic last;
        logic div_start;
        logic div_step;
        logic spc_load;
        logic brk;
    } t_dp_cmd;

    typedef struct packed {
        logic is_nl;
        logic is_tab;
        logic col_zero;
        logic skip_empty;
        logic number_lines;
        logic expand_tabs;
        logic wrap_char;
        logic wrap_tab;
        logic div_done;
        logic spc_last;
        logic pidx_last;
        logic slot_free;
    } t_dp_sts;

endpackage

// File: rtl/core/tlf_in_if.sv
// Input character channel of the text line formatter.
`timescale 1ns / 1ps

interface tlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
    modport mon    (input valid, input char_in, input ready);
endinterface

// File: rtl/core/tlf_out_if.sv
// Output character channel of the text line formatter.
`timescale 1ns / 1ps

interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_of_run;

    modport source (output valid, output char_out, output last_of_run, input ready);
    modport sink   (input valid, input char_out, input last_of_run, output ready);
    modport mon    (input valid, input char_out, input last_of_run, input ready);
endinterface

// File: rtl/core/tlf_ctrl.sv
// Sequencer that walks one input character through prefix, break, tab and emit steps.
`timescale 1ns / 1ps

module tlf_ctrl
    import tlf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_brk, n_brk;
    logic   r_may_break, n_may_break;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_brk       <= 1'b0;
            r_may_break <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_brk       <= n_brk;
            r_may_break <= n_may_break;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_brk       = r_brk;
        n_may_break = r_may_break;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state     = S_START;
                    n_brk       = 1'b0;
                    n_may_break = 1'b1;
                end
            end
            S_START: begin
                if (i_sts.is_nl && i_sts.col_zero && i_sts.skip_empty) begin
                    n_state = S_IDLE;
                end else if (i_sts.col_zero && i_sts.number_lines) begin
                    n_state = S_PREFIX;
                end else begin
                    n_state = S_BODY;
                end
            end
            S_PREFIX: begin
                if (i_sts.slot_free && i_sts.pidx_last) begin
                    n_state = S_BODY;
                end
            end
            S_BODY: begin
                if (i_sts.is_nl) begin
                    if (i_sts.slot_free) begin
                        // A break newline is followed by the pending character.
                        if (r_brk) begin
                            n_state = S_START;
                            n_brk   = 1'b0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (i_sts.is_tab && i_sts.expand_tabs) begin
                    n_state = S_DIV;
                end else if (i_sts.wrap_char && r_may_break) begin
                    n_state     = S_START;
                    n_brk       = 1'b1;
                    n_may_break = 1'b0;
                end else if (i_sts.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_TABCHK;
                end
            end
            S_TABCHK: begin
                if (i_sts.wrap_tab && r_may_break) begin
                    n_state     = S_START;
                    n_brk       = 1'b1;
                    n_may_break = 1'b0;
                end else begin
                    n_state = S_SPACES;
                end
            end
            S_SPACES: begin
                if (i_sts.slot_free && i_sts.spc_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.sel       = SEL_CHAR;
        o_cmd.brk       = r_brk;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_START: begin
            end
            S_PREFIX: begin
                o_cmd.push = i_sts.slot_free;
                o_cmd.sel  = SEL_PREFIX;
            end
            S_BODY: begin
                if (i_sts.is_nl) begin
                    o_cmd.push = i_sts.slot_free;
                    o_cmd.sel  = SEL_NL;
                    o_cmd.last = !r_brk;
                end else if (i_sts.is_tab && i_sts.expand_tabs) begin
                    o_cmd.div_start = 1'b1;
                end else if (!(i_sts.wrap_char && r_may_break)) begin
                    o_cmd.push = i_sts.slot_free;
                    o_cmd.sel  = SEL_CHAR;
                    o_cmd.last = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_TABCHK: begin
                o_cmd.spc_load = !(i_sts.wrap_tab && r_may_break);
            end
            S_SPACES: begin
                o_cmd.push = i_sts.slot_free;
                o_cmd.sel  = SEL_SPACE;
                o_cmd.last = i_sts.spc_last;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/tlf_dp.sv
// Datapath: configuration, column and line counters, tab remainder unit and output register.
`timescale 1ns / 1ps

module tlf_dp
    import tlf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_cfg_idx   i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic [7:0] i_char_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_char_out,
    output logic       o_last_of_run
);

    logic        r_skip_empty;
    logic        r_to_lower;
    logic        r_to_upper;
    logic        r_number_lines;
    logic        r_expand_tabs;
    logic        r_wrap_enable;
    logic [4:0]  r_tab_width;
    logic [7:0]  r_line_width;

    logic [7:0]  r_col;
    logic [19:0] r_bcd;
    logic [2:0]  r_pidx;
    logic [7:0]  r_ch;
    logic [4:0]  r_rem;
    logic [2:0]  r_bit;
    logic [4:0]  r_spc;
    logic        r_ov;
    logic [7:0]  r_oc;
    logic        r_ol;

    logic [4:0]  eff_tw;
    logic [7:0]  eff_w;
    logic [7:0]  cur_ch;
    logic [4:0]  k;
    logic [8:0]  sum_k;
    logic [4:0]  shifted;
    logic [4:0]  rem_next;
    logic        pidx_last;
    logic        slot_free;
    logic [7:0]  push_char;

    function automatic logic [7:0] fold_case(input logic [7:0] ch, input logic lower,
                                             input logic upper);
        logic [7:0] res;
        res = ch;
        if (lower && res >= 8'd65 && res <= 8'd90) begin
            res = res + 8'd32;
        end
        if (upper && res >= 8'd97 && res <= 8'd122) begin
            res = res - 8'd32;
        end
        return res;
    endfunction

    // Leading zero digits print as spaces; the ones digit always prints.
    function automatic logic [7:0] prefix_char(input logic [19:0] bcd, input logic [2:0] pidx);
        logic       seen;
        logic [3:0] dig;
        logic [3:0] cur;
        logic [2:0] target;
        logic [7:0] res;
        seen   = 1'b0;
        dig    = 4'd0;
        target = 3'd4 - pidx;
        for (int d = 4; d >= 0; d--) begin
            cur = bcd[d*4 +: 4];
            if (d >= int'(target) && cur != 4'd0) begin
                seen = 1'b1;
            end
            if (d == int'(target)) begin
                dig = cur;
            end
        end
        if (target == 3'd0) begin
            seen = 1'b1;
        end
        if (pidx == 3'(PREFIX_COLS - 1)) begin
            res = CH_SPACE;
        end else if (seen) begin
            res = CH_ZERO + ((dig > 4'd9) ? 8'd9 : {4'd0, dig});
        end else begin
            res = CH_SPACE;
        end
        return res;
    endfunction

    function automatic logic [19:0] bcd_inc(input logic [19:0] bcd);
        logic [19:0] res;
        logic [3:0]  cur;
        logic        carry;
        res   = '0;
        carry = 1'b1;
        for (int d = 0; d < 5; d++) begin
            cur = bcd[d*4 +: 4];
            if (carry) begin
                if (cur >= 4'd9) begin
                    cur = 4'd0;
                end else begin
                    cur   = cur + 4'd1;
                    carry = 1'b0;
                end
            end
            res[d*4 +: 4] = cur;
        end
        return res;
    endfunction

    always_comb begin
        if (r_tab_width == 5'd0) begin
            eff_tw = 5'd1;
        end else if (r_tab_width > 5'(MAX_TAB)) begin
            eff_tw = 5'(MAX_TAB);
        end else begin
            eff_tw = r_tab_width;
        end
    end

    // The 8-bit register cannot exceed the widest legal line, so only the floor applies.
    assign eff_w     = (r_line_width < MIN_WIDTH) ? MIN_WIDTH : r_line_width;
    assign cur_ch    = i_cmd.brk ? CH_NL : r_ch;
    assign k         = eff_tw - r_rem;
    assign sum_k     = {1'b0, r_col} + {4'd0, k};
    assign shifted   = {r_rem[3:0], r_col[r_bit]};
    assign rem_next  = (shifted >= eff_tw) ? (shifted - eff_tw) : shifted;
    assign pidx_last = (r_pidx == 3'(PREFIX_COLS - 1));
    assign slot_free = !r_ov || i_out_ready;

    always_comb begin
        unique case (i_cmd.sel)
            SEL_PREFIX: push_char = prefix_char(r_bcd, r_pidx);
            SEL_NL:     push_char = CH_NL;
            SEL_CHAR:   push_char = cur_ch;
            SEL_SPACE:  push_char = CH_SPACE;
            default:    push_char = cur_ch;
        endcase
    end

    always_comb begin
        o_sts.is_nl        = (cur_ch == CH_NL);
        o_sts.is_tab       = (cur_ch == CH_TAB);
        o_sts.col_zero     = (r_col == 8'd0);
        o_sts.skip_empty   = r_skip_empty;
        o_sts.number_lines = r_number_lines;
        o_sts.expand_tabs  = r_expand_tabs;
        o_sts.wrap_char    = r_wrap_enable && (r_col >= eff_w);
        o_sts.wrap_tab     = r_wrap_enable && (sum_k >= {1'b0, eff_w});
        o_sts.div_done     = (r_bit == 3'd0);
        o_sts.spc_last     = (r_spc == 5'd1);
        o_sts.pidx_last    = pidx_last;
        o_sts.slot_free    = slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_empty   <= 1'b0;
            r_to_lower     <= 1'b0;
            r_to_upper     <= 1'b0;
            r_number_lines <= 1'b0;
            r_expand_tabs  <= 1'b0;
            r_wrap_enable  <= 1'b0;
            r_tab_width    <= 5'd4;
            r_line_width   <= 8'd80;
            r_col          <= 8'd0;
            r_bcd          <= 20'd1;
            r_pidx         <= 3'd0;
            r_ov           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SKIP_EMPTY:   r_skip_empty   <= i_cfg_data[0];
                    CFG_TO_LOWER:     r_to_lower     <= i_cfg_data[0];
                    CFG_TO_UPPER:     r_to_upper     <= i_cfg_data[0];
                    CFG_NUMBER_LINES: r_number_lines <= i_cfg_data[0];
                    CFG_EXPAND_TABS:  r_expand_tabs  <= i_cfg_data[0];
                    CFG_WRAP_ENABLE:  r_wrap_enable  <= i_cfg_data[0];
                    CFG_TAB_WIDTH:    r_tab_width    <= i_cfg_data[4:0];
                    CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.push) begin
                r_ov <= 1'b1;
                unique case (i_cmd.sel)
                    SEL_PREFIX: begin
                        if (pidx_last) begin
                            r_pidx <= 3'd0;
                            r_col  <= 8'(PREFIX_COLS);
                            r_bcd  <= bcd_inc(r_bcd);
                        end else begin
                            r_pidx <= r_pidx + 3'd1;
                        end
                    end
                    SEL_NL: begin
                        r_col <= 8'd0;
                    end
                    SEL_CHAR, SEL_SPACE: begin
                        if (r_col != COL_MAX) begin
                            r_col <= r_col + 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch <= (i_char_in == CH_NL) ? i_char_in
                                         : fold_case(i_char_in, r_to_lower, r_to_upper);
        end
        if (i_cmd.div_start) begin
            r_rem <= 5'd0;
            r_bit <= 3'd7;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_next;
            r_bit <= r_bit - 3'd1;
        end
        if (i_cmd.spc_load) begin
            r_spc <= k;
        end else if (i_cmd.push && i_cmd.sel == SEL_SPACE) begin
            r_spc <= r_spc - 5'd1;
        end
        if (i_cmd.push) begin
            r_oc <= push_char;
            r_ol <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_char_out    = r_oc;
    assign o_last_of_run = r_ol;

endmodule

// File: rtl/core/text_line_formatter_unit.sv
// Character stream formatter: case folding, empty-line drop, line numbers, tabs and wrapping.
// The block takes one character at a time and answers with a run of zero to 17 output
// characters, the last of which carries last_of_run. It works on one character at a time:
// an ordinary character or newline passes a start step and an emit step, a line-number
// prefix adds one emit step per prefix character, an expanded tab adds the bit-serial
// remainder of the column by the tab width, a check against the line width and one emit
// step per space, and an automatic line break runs the newline and the character through
// the sequencer again. The output register emits one character per cycle while the sink is
// ready, so a stalled output holds the sequencer at its current emit step. A new character
// is taken while the last output of the previous one still waits in the output register.
`timescale 1ns / 1ps

module text_line_formatter_unit
    import tlf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [7:0]      i_cfg_data,
    tlf_in_if.sink          i_in,
    tlf_out_if.source       o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    tlf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tlf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data    (i_cfg_data),
        .i_char_in     (i_in.char_in),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_char_out    (o_out.char_out),
        .o_last_of_run (o_out.last_of_run)
    );

    assign i_in.ready = in_ready;

endmodule

// File: rtl/core/tlf_checker.sv
// Port-level checker for the text line formatter and its bind to the top level.
`timescale 1ns / 1ps
`include "text_line_formatter_unit_macros.svh"

module tlf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    logic [9:0] out_word;

    assign out_word = {i_out_valid, i_out_char, i_out_last};

    // One character is processed at a time, so a transaction on the input closes the input.
    `TLF_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // While a run is unfinished the block must not take the next character.
    `TLF_ASSERT_NOW(a_run_open, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready)

    `TLF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(out_word))

endmodule

bind text_line_formatter_unit tlf_checker u_tlf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_out),
    .i_out_last  (o_out.last_of_run)
);
